FILE: rtl/assert_macros.svh
// Assertion macros used by the scroller top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

FILE: rtl/lmcs_pkg.sv
// Types and constants of the column scroller.
`default_nettype none
package lmcs_pkg;

  localparam int ROWS  = 8;
  localparam int PIX_W = 5;
  localparam int COL_W = ROWS * PIX_W;
  localparam int BYTE_W = 8;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_TICK      = 3'd1,
    OP_NEIGHBOUR = 3'd2,
    OP_RESTART   = 3'd3,
    OP_READ      = 3'd4
  } opcode_e;

  // configuration register indexes
  localparam logic CFG_IMAGE_WIDTH = 1'b0;
  localparam logic CFG_GAP_LENGTH  = 1'b1;

  localparam logic [8:0] IMAGE_WIDTH_RST = 9'd8;
  localparam logic [3:0] GAP_LENGTH_RST  = 4'd8;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [10:0]      pixel_address;
    logic [7:0]       pixel_value;
    logic [COL_W-1:0] neighbour_column;
    logic [2:0]       read_index;
  } req_t;

  typedef struct packed {
    logic [COL_W-1:0] column_out;
    logic             is_read_reply;
  } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/lmcs_stream_if.sv
// Valid/ready stream channel.
`default_nettype none
interface lmcs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/lmcs_image_store.sv
// Image store: one bank per row, one column of all rows read per cycle.
`default_nettype none
module lmcs_image_store #(
  parameter int COLS = 256,
  parameter int COL_AW = $clog2(COLS)
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [2:0]                            wr_row_i,
  input  wire logic [COL_AW-1:0]                     wr_col_i,
  input  wire logic [lmcs_pkg::BYTE_W-1:0]           wr_data_i,
  input  wire logic                                  re_i,
  input  wire logic [COL_AW-1:0]                     rd_col_i,
  output logic [lmcs_pkg::ROWS*lmcs_pkg::BYTE_W-1:0] rd_data_o
);

  for (genvar r = 0; r < lmcs_pkg::ROWS; r++) begin : g_bank
    logic [lmcs_pkg::BYTE_W-1:0] mem [COLS];
    logic [lmcs_pkg::BYTE_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (we_i && (wr_row_i == 3'(r))) begin
        mem[wr_col_i] <= wr_data_i;
      end
      if (re_i) begin
        rd_q <= mem[rd_col_i];
      end
    end

    assign rd_data_o[r*lmcs_pkg::BYTE_W +: lmcs_pkg::BYTE_W] = rd_q;
  end

endmodule
`default_nettype wire

FILE: rtl/lmcs_column_cell.sv
// One frame column; takes its right neighbour's column on a shift.
`default_nettype none
module lmcs_column_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         shift_i,
  input  wire logic [lmcs_pkg::COL_W-1:0]   col_i,
  output logic [lmcs_pkg::COL_W-1:0]        col_o
);

  logic [lmcs_pkg::COL_W-1:0] col_q, col_d;

  assign col_d = shift_i ? col_i : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule
`default_nettype wire

FILE: rtl/led_matrix_column_scroller.sv
// Column scroller top level: request decode, image store, frame cell chain.
// Tick, neighbour and read requests pass stage 1; the output register holds the result.
// Throughput: one request per cycle unless results stall; one store read per request.
// Load and restart requests give no result and finish in the cycle they are taken.
// Reset: frame blank, image index 0, gap 8, image width 8, gap length 8.
// The image store is not cleared by reset.
`default_nettype none
`include "assert_macros.svh"
module led_matrix_column_scroller #(
  parameter int DISPLAY_COLUMNS   = 8,
  parameter int IMAGE_MAX_COLUMNS = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [8:0] cfg_wdata_i,
  lmcs_stream_if.sink     req_i,
  lmcs_stream_if.source   rsp_o
);

  localparam int StoreDepth = IMAGE_MAX_COLUMNS * 8;
  localparam int ColAw      = $clog2(IMAGE_MAX_COLUMNS);
  localparam int ColW       = lmcs_pkg::COL_W;

  typedef struct packed {
    lmcs_pkg::opcode_e op;
    logic              gap_zero;
    logic [ColW-1:0]   ncol;
    logic [2:0]        ridx;
  } s1_t;

  // configuration
  logic [8:0] width_q;
  logic [3:0] gap_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= lmcs_pkg::IMAGE_WIDTH_RST;
      gap_len_q <= lmcs_pkg::GAP_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lmcs_pkg::CFG_IMAGE_WIDTH: width_q   <= cfg_wdata_i;
        lmcs_pkg::CFG_GAP_LENGTH:  gap_len_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q, s1_valid_d;
  s1_t  s1_q;
  logic out_valid_q, out_valid_d;
  lmcs_pkg::rsp_t out_q;
  logic out_free, s1_move, accept;
  lmcs_pkg::opcode_e op_in;
  logic has_result;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign s1_move  = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;
  assign accept   = req_i.valid && req_i.ready;
  assign op_in    = lmcs_pkg::opcode_e'(req_i.payload.opcode);
  assign has_result = (op_in == lmcs_pkg::OP_TICK) || (op_in == lmcs_pkg::OP_NEIGHBOUR) ||
                      (op_in == lmcs_pkg::OP_READ);

  // image position state
  logic [7:0]       idx_q, idx_d;
  logic [ColAw-1:0] scol_q, scol_d;
  logic [3:0]       gap_q, gap_d;
  logic [8:0]       idx_next;
  logic             wrap;

  assign idx_next = {1'b0, idx_q} + 9'd1;
  assign wrap     = idx_next[8] || (idx_next >= width_q);

  always_comb begin
    idx_d  = idx_q;
    scol_d = scol_q;
    gap_d  = gap_q;
    if (accept) begin
      case (op_in)
        lmcs_pkg::OP_TICK: begin
          if (gap_q != 4'd0) begin
            gap_d = gap_q - 4'd1;
          end else if (wrap) begin
            idx_d  = '0;
            scol_d = '0;
            gap_d  = gap_len_q;
          end else begin
            idx_d  = idx_next[7:0];
            // store column follows the index modulo the store width
            scol_d = (scol_q == ColAw'(IMAGE_MAX_COLUMNS - 1)) ? '0 : scol_q + 1'b1;
          end
        end
        lmcs_pkg::OP_RESTART: begin
          idx_d  = '0;
          scol_d = '0;
          gap_d  = gap_len_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      scol_q <= '0;
      gap_q  <= lmcs_pkg::GAP_LENGTH_RST;
    end else begin
      idx_q  <= idx_d;
      scol_q <= scol_d;
      gap_q  <= gap_d;
    end
  end

  // image store
  logic                                    load_we;
  logic [lmcs_pkg::ROWS*lmcs_pkg::BYTE_W-1:0] rd_data;

  assign load_we = accept && (op_in == lmcs_pkg::OP_LOAD) &&
                   (32'(req_i.payload.pixel_address) < StoreDepth);

  lmcs_image_store #(
    .COLS   (IMAGE_MAX_COLUMNS),
    .COL_AW (ColAw)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (load_we),
    .wr_row_i  (req_i.payload.pixel_address[2:0]),
    .wr_col_i  (ColAw'(req_i.payload.pixel_address[10:3])),
    .wr_data_i (req_i.payload.pixel_value),
    .re_i      (accept),
    .rd_col_i  (scol_q),
    .rd_data_o (rd_data)
  );

  // stage 1: requests that give a result
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (req_i.ready) begin
      s1_valid_d = accept && has_result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.op       <= op_in;
      s1_q.gap_zero <= (gap_q == 4'd0);
      s1_q.ncol     <= req_i.payload.neighbour_column;
      s1_q.ridx     <= req_i.payload.read_index;
    end
  end

  // frame cell chain
  logic [ColW-1:0] cols [DISPLAY_COLUMNS];
  logic [ColW-1:0] insert_col;
  logic            shift;

  assign shift = s1_move && (s1_q.op != lmcs_pkg::OP_READ);

  always_comb begin
    insert_col = s1_q.ncol;
    if (s1_q.op == lmcs_pkg::OP_TICK) begin
      for (int r = 0; r < lmcs_pkg::ROWS; r++) begin
        insert_col[r*lmcs_pkg::PIX_W +: lmcs_pkg::PIX_W] = s1_q.gap_zero ?
          rd_data[r*lmcs_pkg::BYTE_W + 3 +: lmcs_pkg::PIX_W] : '0;
      end
    end
  end

  for (genvar c = 0; c < DISPLAY_COLUMNS; c++) begin : g_cell
    logic [ColW-1:0] from_right;
    if (c == DISPLAY_COLUMNS - 1) begin : g_last
      assign from_right = insert_col;
    end else begin : g_mid
      assign from_right = cols[c+1];
    end
    lmcs_column_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .col_i   (from_right),
      .col_o   (cols[c])
    );
  end

  // read selection; indexes past the frame read as blank
  logic [ColW-1:0] read_col;

  always_comb begin
    read_col = '0;
    for (int c = 0; c < DISPLAY_COLUMNS; c++) begin
      if (32'(s1_q.ridx) == c) begin
        read_col = cols[c];
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.is_read_reply <= (s1_q.op == lmcs_pkg::OP_READ);
      out_q.column_out    <= (s1_q.op == lmcs_pkg::OP_READ) ? read_col : cols[0];
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  `ASSERT_IMPLIES(a_gap_idx_zero, clk_i, rst_ni, gap_q != 4'd0, idx_q == 8'd0,
                  "gap running with nonzero image index")
  `ASSERT_IMPLIES(a_scol_follows, clk_i, rst_ni, idx_q == 8'd0, scol_q == '0,
                  "store column out of step with image index")
  `ASSERT_IMPLIES(a_full_blocks, clk_i, rst_ni,
                  out_valid_q && !rsp_o.ready && s1_valid_q, !req_i.ready,
                  "request taken with both stages full")
  `ASSERT_NEXT(a_out_source, clk_i, rst_ni, !out_valid_q && !s1_valid_q, !out_valid_q,
               "result appeared without a stage 1 entry")

endmodule
`default_nettype wire

FILE: tb/led_matrix_column_scroller_tb.sv
// Self-checking testbench for the LED matrix column scroller.
module led_matrix_column_scroller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmcs_pkg::*;

  localparam int NCOLS          = 8;
  localparam int IMG_COLS       = 256;
  localparam int STORE_DEPTH    = IMG_COLS * ROWS;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_PAD      = 4;
  localparam int PHASE_ITEMS    = 115;
  localparam int MAX_REPORTS    = 10;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic       cfg_idx;
  logic [8:0] cfg_wdata;

  lmcs_stream_if #(.payload_t(req_t)) req_if ();
  lmcs_stream_if #(.payload_t(rsp_t)) rsp_if ();

  led_matrix_column_scroller #(
    .DISPLAY_COLUMNS  (NCOLS),
    .IMAGE_MAX_COLUMNS(IMG_COLS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // scroller state as predicted
  logic [PIX_W-1:0]  frame_q [NCOLS][ROWS];
  logic [BYTE_W-1:0] image_q [STORE_DEPTH];
  bit                loaded_q [STORE_DEPTH];
  logic [7:0]        index_q;
  logic [3:0]        gap_q;
  logic [8:0]        width_q;
  logic [3:0]        gap_len_q;
  rsp_t              pending_columns [$];

  int  fail_count;
  int  stall_cycles;
  int  ready_hold;
  bit  req_idle;
  bit  rsp_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int idle_len(bit enabled);
    int roll;
    roll = $urandom_range(0, 99);
    if (!enabled || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [COL_W-1:0] frame_column(int c);
    logic [COL_W-1:0] col;
    col = '0;
    for (int r = 0; r < ROWS; r++) col[r*PIX_W +: PIX_W] = frame_q[c][r];
    return col;
  endfunction

  // leftmost column leaves, the rest move one place left
  function automatic logic [COL_W-1:0] shift_frame();
    logic [COL_W-1:0] sent;
    sent = frame_column(0);
    for (int c = 0; c < NCOLS - 1; c++)
      for (int r = 0; r < ROWS; r++) frame_q[c][r] = frame_q[c+1][r];
    return sent;
  endfunction

  function automatic void advance_image();
    logic [9:0] nxt;
    if (gap_q != 4'd0) begin
      gap_q = gap_q - 4'd1;
      return;
    end
    nxt = {2'b00, index_q} + 10'd1;
    if (nxt >= {1'b0, width_q} || nxt >= 10'd256) begin
      index_q = '0;
      gap_q   = gap_len_q;
    end else begin
      index_q = nxt[7:0];
    end
  endfunction

  function automatic void scroll_step(req_t item);
    rsp_t res;
    case (item.opcode)
      OP_LOAD: begin
        image_q[item.pixel_address]  = item.pixel_value;
        loaded_q[item.pixel_address] = 1'b1;
      end
      OP_TICK: begin
        res.column_out    = shift_frame();
        res.is_read_reply = 1'b0;
        for (int r = 0; r < ROWS; r++)
          frame_q[NCOLS-1][r] = (gap_q == 4'd0) ? image_q[{index_q, 3'(r)}][7:3] : '0;
        advance_image();
        pending_columns.push_back(res);
      end
      OP_NEIGHBOUR: begin
        res.column_out    = shift_frame();
        res.is_read_reply = 1'b0;
        for (int r = 0; r < ROWS; r++)
          frame_q[NCOLS-1][r] = item.neighbour_column[r*PIX_W +: PIX_W];
        pending_columns.push_back(res);
      end
      OP_RESTART: begin
        index_q = '0;
        gap_q   = gap_len_q;
      end
      OP_READ: begin
        res.column_out    = (item.read_index < NCOLS) ? frame_column(item.read_index) : '0;
        res.is_read_reply = 1'b1;
        pending_columns.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // register writes and requests are predicted before results are checked
  always @(posedge clk_i) begin : scoreboard
    rsp_t got;
    rsp_t want;
    if (rst_ni) begin
      if (cfg_we) begin
        if (cfg_idx == CFG_IMAGE_WIDTH) width_q = cfg_wdata;
        else gap_len_q = cfg_wdata[3:0];
      end
      if (req_if.valid && req_if.ready) scroll_step(req_if.payload);
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        if (pending_columns.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: column %h reply %b", got.column_out,
                     got.is_read_reply);
        end else begin
          want = pending_columns.pop_front();
          if (got.column_out !== want.column_out ||
              got.is_read_reply !== want.is_read_reply) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch: expected column %h reply %b, got column %h reply %b",
                       want.column_out, want.is_read_reply, got.column_out,
                       got.is_read_reply);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result backpressure
  initial begin
    rsp_if.ready = 1'b0;
    ready_hold   = 0;
    forever begin
      @(negedge clk_i);
      if (ready_hold != 0) begin
        rsp_if.ready = 1'b0;
        ready_hold--;
      end else begin
        rsp_if.ready = 1'b1;
        ready_hold   = idle_len(rsp_idle);
      end
    end
  end

  // entered and left at a falling edge, valid low on return
  task automatic send_request(req_t item);
    int gap;
    gap = idle_len(req_idle);
    repeat (gap) @(negedge clk_i);
    req_if.payload = item;
    req_if.valid   = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  function automatic req_t rand_request(logic [2:0] op);
    req_t item;
    logic [63:0] wide;
    wide                  = {$urandom, $urandom};
    item.opcode           = op;
    item.pixel_address    = 11'($urandom);
    item.pixel_value      = 8'($urandom);
    item.neighbour_column = wide[COL_W-1:0];
    item.read_index       = 3'($urandom);
    return item;
  endfunction

  task automatic load_pixel(logic [10:0] addr, logic [7:0] value);
    req_t item;
    item               = rand_request(OP_LOAD);
    item.pixel_address = addr;
    item.pixel_value   = value;
    send_request(item);
  endtask

  task automatic read_column(logic [2:0] idx);
    req_t item;
    item            = rand_request(OP_READ);
    item.read_index = idx;
    send_request(item);
  endtask

  task automatic push_neighbour(logic [COL_W-1:0] col);
    req_t item;
    item                  = rand_request(OP_NEIGHBOUR);
    item.neighbour_column = col;
    send_request(item);
  endtask

  // a tick that fetches the image only after its column has been loaded
  task automatic master_tick();
    logic [10:0] addr;
    if (gap_q == 4'd0) begin
      for (int r = 0; r < ROWS; r++) begin
        addr = {index_q, 3'(r)};
        if (!loaded_q[addr]) load_pixel(addr, 8'($urandom));
      end
    end
    send_request(rand_request(OP_TICK));
  endtask

  task automatic wait_quiet();
    while (pending_columns.size() != 0) @(negedge clk_i);
    repeat (DRAIN_PAD) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [8:0] data);
    wait_quiet();
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // blank frame and running gap after reset, spare opcodes ignored
  task automatic test_reset_state();
    read_column(3'd0);
    read_column(3'd7);
    master_tick();
    master_tick();
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) send_request(rand_request(3'(op)));
  endtask

  // one-column image with no gap, pixel extremes, neighbour insertion
  task automatic test_image_path();
    logic [7:0] pix [ROWS];
    pix = '{8'd0, 8'd255, 8'd7, 8'd8, 8'd248, 8'h80, 8'h7f, 8'd1};
    write_reg(CFG_IMAGE_WIDTH, 9'd1);
    write_reg(CFG_GAP_LENGTH, 9'd0);
    send_request(rand_request(OP_RESTART));
    for (int r = 0; r < ROWS; r++) load_pixel(11'(r), pix[r]);
    load_pixel(11'h7ff, 8'hff);
    master_tick();
    master_tick();
    push_neighbour('1);
    push_neighbour('0);
    read_column(3'd7);
    read_column(3'd6);
  endtask

  task automatic test_random_scroll();
    int widths [8];
    int gaps [8];
    int done;
    int roll;
    logic [10:0] addr;
    widths = '{8, 1, 256, 0, 511, 3, $urandom_range(2, 16), $urandom_range(1, 40)};
    gaps   = '{8, 0, 15, 2, 1, 0, $urandom_range(0, 15), $urandom_range(0, 15)};
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_IMAGE_WIDTH, 9'(widths[p]));
      write_reg(CFG_GAP_LENGTH, 9'(gaps[p]));
      req_idle = (p % 3 != 0);
      rsp_idle = (p % 4 != 1);
      done = 0;
      while (done < PHASE_ITEMS) begin
        if (done == PHASE_ITEMS / 2 && p % 2 == 0) wait_quiet();
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          master_tick();
        end else if (roll < 55) begin
          send_request(rand_request(OP_NEIGHBOUR));
        end else if (roll < 72) begin
          send_request(rand_request(OP_READ));
        end else if (roll < 87) begin
          addr = $urandom_range(0, 1) ? {index_q, 3'($urandom)} : 11'($urandom);
          load_pixel(addr, 8'($urandom));
        end else if (roll < 92) begin
          send_request(rand_request(OP_RESTART));
        end else begin
          send_request(rand_request(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))));
          done--;
        end
        done++;
      end
    end
  endtask

  initial begin : stimulus
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_IMAGE_WIDTH;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    req_idle       = 1'b0;
    rsp_idle       = 1'b0;
    fail_count     = 0;
    stall_cycles   = 0;
    for (int c = 0; c < NCOLS; c++)
      for (int r = 0; r < ROWS; r++) frame_q[c][r] = '0;
    index_q   = '0;
    gap_q     = GAP_LENGTH_RST;
    width_q   = IMAGE_WIDTH_RST;
    gap_len_q = GAP_LENGTH_RST;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_image_path();
    test_random_scroll();

    wait_quiet();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending_columns.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
